// ===== rtl/core/btoa_pkg.sv =====
package btoa_pkg;

  localparam int unsigned StoreDepth  = 20;
  localparam int unsigned DigitW      = 4;
  localparam int unsigned CntW        = 5;
  localparam int unsigned ValueW      = 64;
  localparam int unsigned HalfW       = 32;
  localparam int unsigned DecDigits32 = 10;
  localparam int unsigned HexDigits32 = 8;
  localparam int unsigned HexDigits64 = 16;
  localparam int unsigned QueueDepth  = 2;

  localparam logic [7:0] AsciiZero = 8'h30;
  localparam logic [7:0] AsciiA    = 8'h41;

  typedef logic [StoreDepth-1:0][DigitW-1:0] digits_t;

  // one classified conversion job
  typedef struct packed {
    logic              hex;
    logic              wide;
    logic [ValueW-1:0] value;
    logic [CntW-1:0]   dec_limit;
  } job_t;

  function automatic logic [7:0] ascii_of(input logic [DigitW-1:0] d);
    logic [7:0] c;
    if (d < 4'd10) begin
      c = AsciiZero + {4'b0000, d};
    end else begin
      c = AsciiA + {4'b0000, d - 4'd10};
    end
    return c;
  endfunction

endpackage

// ===== rtl/core/btoa_front.sv =====
module btoa_front #(
  parameter int unsigned MAX_DEC_DIGITS = 20
) (
  input  logic                        in_valid_i,
  output logic                        in_ready_o,
  input  logic                        kind_i,
  input  logic                        wide_i,
  input  logic [btoa_pkg::ValueW-1:0] value_i,
  input  logic                        q_full_i,
  output logic                        push_o,
  output btoa_pkg::job_t              job_o
);

  // digit limit above the store depth is treated as the store depth
  localparam int unsigned LimitWide =
      (MAX_DEC_DIGITS > btoa_pkg::StoreDepth) ? btoa_pkg::StoreDepth : MAX_DEC_DIGITS;

  assign in_ready_o = !q_full_i;
  assign push_o     = in_valid_i && !q_full_i;

  always_comb begin
    job_o.hex  = kind_i;
    job_o.wide = wide_i;
    if (wide_i) begin
      job_o.value     = value_i;
      job_o.dec_limit = btoa_pkg::CntW'(LimitWide);
    end else begin
      job_o.value     = {{btoa_pkg::HalfW{1'b0}}, value_i[btoa_pkg::HalfW-1:0]};
      job_o.dec_limit = btoa_pkg::CntW'(btoa_pkg::DecDigits32);
    end
  end

endmodule

// ===== rtl/core/btoa_queue.sv =====
module btoa_queue (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           push_i,
  input  btoa_pkg::job_t job_i,
  output logic           full_o,
  input  logic           pop_i,
  output logic           valid_o,
  output btoa_pkg::job_t job_o
);

  localparam int unsigned PtrW = $clog2(btoa_pkg::QueueDepth);
  localparam int unsigned CntQW = $clog2(btoa_pkg::QueueDepth + 1);

  btoa_pkg::job_t entry_q [btoa_pkg::QueueDepth];
  logic [PtrW-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CntQW-1:0] count_q;

  assign full_o  = (count_q == CntQW'(btoa_pkg::QueueDepth));
  assign valid_o = (count_q != '0);
  assign job_o   = entry_q[rd_ptr_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= (wr_ptr_q == PtrW'(btoa_pkg::QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= (rd_ptr_q == PtrW'(btoa_pkg::QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      unique case ({push_i, pop_i})
        2'b10:   count_q <= count_q + 1'b1;
        2'b01:   count_q <= count_q - 1'b1;
        default: count_q <= count_q;
      endcase
    end
  end

endmodule

// ===== rtl/core/btoa_back.sv =====
module btoa_back (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           q_valid_i,
  input  btoa_pkg::job_t q_job_i,
  output logic           pop_o,
  output logic           out_valid_o,
  input  logic           out_ready_i,
  output logic [7:0]     char_out_o,
  output logic           last_o
);

  localparam int unsigned CntW = btoa_pkg::CntW;

  typedef enum logic [1:0] {StIdle, StConv, StEmit} state_e;

  state_e                    state_q;
  logic [CntW-1:0]           cnt_q, step_q, idx_q, lim_q;
  logic                      out_valid_q, last_q;
  logic [7:0]                char_q;
  btoa_pkg::digits_t         digits_q, hex_digits, d1, d2;
  logic [btoa_pkg::ValueW-1:0] sh_q;
  logic [CntW-1:0]           cnt1, cnt2, n_dec;
  logic                      load_job, conv_step, out_take;

  // one double-dabble bit: add 3 to digits of 5 or more, then shift the bit in
  function automatic btoa_pkg::digits_t dabble(input btoa_pkg::digits_t d, input logic b);
    btoa_pkg::digits_t c;
    logic [btoa_pkg::StoreDepth*btoa_pkg::DigitW-1:0] flat;
    for (int i = 0; i < btoa_pkg::StoreDepth; i++) begin
      c[i] = (d[i] >= 4'd5) ? d[i] + 4'd3 : d[i];
    end
    flat = c;
    return {flat[btoa_pkg::StoreDepth*btoa_pkg::DigitW-2:0], b};
  endfunction

  // the significant length grows by at most one digit per shifted bit
  function automatic logic [CntW-1:0] grow(input btoa_pkg::digits_t d,
                                           input logic [CntW-1:0] c);
    logic [CntW-1:0] r;
    r = c;
    if (c < CntW'(btoa_pkg::StoreDepth)) begin
      if (d[c] != '0) begin
        r = c + 1'b1;
      end
    end
    return r;
  endfunction

  assign load_job  = (state_q == StIdle) && q_valid_i;
  assign pop_o     = load_job;
  assign conv_step = (state_q == StConv);
  assign out_take  = !out_valid_q || out_ready_i;

  always_comb begin
    d1    = dabble(digits_q, sh_q[btoa_pkg::ValueW-1]);
    cnt1  = grow(d1, cnt_q);
    d2    = dabble(d1, sh_q[btoa_pkg::ValueW-2]);
    cnt2  = grow(d2, cnt1);
    if (cnt2 == '0) begin
      n_dec = CntW'(1);
    end else if (cnt2 > lim_q) begin
      n_dec = lim_q;
    end else begin
      n_dec = cnt2;
    end
    for (int i = 0; i < btoa_pkg::StoreDepth; i++) begin
      hex_digits[i] = '0;
    end
    for (int i = 0; i < btoa_pkg::HexDigits64; i++) begin
      hex_digits[i] = q_job_i.value[btoa_pkg::DigitW*i +: btoa_pkg::DigitW];
    end
  end

  // digit store and shift register, no reset
  always_ff @(posedge clk_i) begin
    if (load_job) begin
      digits_q <= q_job_i.hex ? hex_digits : '0;
      sh_q     <= q_job_i.wide ? q_job_i.value
                : {q_job_i.value[btoa_pkg::HalfW-1:0], {btoa_pkg::HalfW{1'b0}}};
    end else if (conv_step) begin
      digits_q <= d2;
      sh_q     <= {sh_q[btoa_pkg::ValueW-3:0], 2'b00};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= StIdle;
      cnt_q       <= '0;
      step_q      <= '0;
      idx_q       <= '0;
      lim_q       <= '0;
      out_valid_q <= 1'b0;
      char_q      <= '0;
      last_q      <= 1'b0;
    end else begin
      // output slot frees on a transfer and refills while emitting
      if (out_take) begin
        out_valid_q <= (state_q == StEmit);
      end
      unique case (state_q)
        StIdle: begin
          if (q_valid_i) begin
            if (q_job_i.hex) begin
              idx_q   <= q_job_i.wide ? CntW'(btoa_pkg::HexDigits64 - 1)
                                      : CntW'(btoa_pkg::HexDigits32 - 1);
              state_q <= StEmit;
            end else begin
              cnt_q   <= '0;
              lim_q   <= q_job_i.dec_limit;
              step_q  <= q_job_i.wide ? CntW'(btoa_pkg::ValueW / 2 - 1)
                                      : CntW'(btoa_pkg::HalfW / 2 - 1);
              state_q <= StConv;
            end
          end
        end
        StConv: begin
          cnt_q  <= cnt2;
          step_q <= step_q - 1'b1;
          if (step_q == '0) begin
            idx_q   <= n_dec - 1'b1;
            state_q <= StEmit;
          end
        end
        StEmit: begin
          if (out_take) begin
            char_q      <= btoa_pkg::ascii_of(digits_q[idx_q]);
            last_q      <= (idx_q == '0);
            if (idx_q == '0) begin
              state_q <= StIdle;
            end else begin
              idx_q <= idx_q - 1'b1;
            end
          end
        end
        default: state_q <= StIdle;
      endcase
    end
  end

  assign out_valid_o = out_valid_q;
  assign char_out_o  = char_q;
  assign last_o      = last_q;

`ifndef ASSERT_OFF
  a_idx_in_store: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StEmit) |-> (idx_q < CntW'(btoa_pkg::StoreDepth)))
    else $error("emit index beyond digit store");

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !out_ready_i) |=> (out_valid_q && $stable(char_q) && $stable(last_q)))
    else $error("stalled character changed or dropped");

  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == StConv) |-> (cnt_q <= CntW'(btoa_pkg::StoreDepth)))
    else $error("decimal digit count overflow");

  a_pop_only_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pop_o |=> (state_q == StConv || state_q == StEmit))
    else $error("job taken without starting conversion");
`endif

endmodule

// ===== rtl/core/binary_to_ascii_dec_hex.sv =====
// binary_to_ascii_dec_hex turns one unsigned 32- or 64-bit value into ASCII
// characters, most significant first, one character per output transfer, with
// last_o high on the final character. kind_i = 1 gives upper-case hex padded
// to 8 or 16 characters; kind_i = 0 gives only the significant decimal digits
// (a zero gives a single '0'), at most 10 for 32-bit values and at most
// MAX_DEC_DIGITS (clamped to 20) for 64-bit values, keeping the lowest digits
// if the limit cuts in. Items pass a classifier and a two-entry job queue, so
// up to two further items are taken while one is being converted. A hex item
// is picked up and then streams its 8 or 16 characters. A decimal item is
// picked up, then runs through a double-dabble converter that shifts two bits
// per cycle, then streams its digits. The output register lets characters
// drain under backpressure without losing any.
module binary_to_ascii_dec_hex #(
  parameter int unsigned MAX_DEC_DIGITS = 20
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  logic        kind_i,
  input  logic        wide_i,
  input  logic [63:0] value_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output logic [7:0]  char_out_o,
  output logic        last_o
);

  // classified jobs on their way into and out of the queue
  btoa_pkg::job_t push_job, pop_job;
  logic           push, q_full, q_valid, pop;

  // front: take the transfer, mask the value and pick the digit limit
  btoa_front #(
    .MAX_DEC_DIGITS(MAX_DEC_DIGITS)
  ) u_front (
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .kind_i    (kind_i),
    .wide_i    (wide_i),
    .value_i   (value_i),
    .q_full_i  (q_full),
    .push_o    (push),
    .job_o     (push_job)
  );

  // short queue so the front keeps accepting while the back works
  btoa_queue u_queue (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (push),
    .job_i  (push_job),
    .full_o (q_full),
    .pop_i  (pop),
    .valid_o(q_valid),
    .job_o  (pop_job)
  );

  // back: convert to digits, then stream characters out
  btoa_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_job_i    (pop_job),
    .pop_o      (pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .char_out_o (char_out_o),
    .last_o     (last_o)
  );

endmodule
